// File: hw/rtl/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg
// shared types and constants for the dispersion tensor pipeline
// ----------------------------------------------------------------------------
package dtv_pkg;

  localparam int DTV_DIM    = 3;
  localparam int DEN_W      = 48;
  localparam int NUM_W      = 96;
  localparam int QUO_W      = 32;
  localparam int NLANE      = 6;
  localparam int ROOT_W     = 32;

  // register indexes
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_DIFF   = 2'd1;
  localparam logic [1:0] REG_ALONG  = 2'd2;
  localparam logic [1:0] REG_ATRANS = 2'd3;

  typedef logic [NLANE-1:0][DEN_W-1:0] rem_arr_t;
  typedef logic [NLANE-1:0][QUO_W-1:0] quo_arr_t;

  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       sgn;
    logic [30:0]      dp;
    logic [30:0]      al;
    logic [30:0]      at;
  } s0_t;

  typedef struct packed {
    logic [2:0][63:0] sq;
    logic [2:0][63:0] pr;
    logic [30:0]      dp;
    logic [30:0]      al;
    logic [30:0]      at;
    logic [30:0]      dmag;
    logic [2:0]       neg;
  } s1_t;

  typedef struct packed {
    logic [63:0]      sum;
    logic [2:0][63:0] rest;
    logic [2:0][63:0] sq;
    logic [2:0][63:0] pr;
    logic [30:0]      dp;
    logic [30:0]      al;
    logic [30:0]      at;
    logic [30:0]      dmag;
    logic [2:0]       neg;
  } s2_t;

  typedef struct packed {
    logic [63:0]      sum;
    logic [2:0][62:0] pal_lo;
    logic [2:0][62:0] pal_hi;
    logic [2:0][62:0] pat_lo;
    logic [2:0][62:0] pat_hi;
    logic [2:0][62:0] poff_lo;
    logic [2:0][62:0] poff_hi;
    logic [30:0]      dp;
    logic [2:0]       neg;
  } s3_t;

  typedef struct packed {
    logic [63:0]            sum;
    logic [2:0][NUM_W-1:0]  na;
    logic [2:0][NUM_W-1:0]  nb;
    logic [2:0][NUM_W-1:0]  noff;
    logic [30:0]            dp;
    logic [2:0]             neg;
  } s4_t;

  // carried alongside the square root chain
  typedef struct packed {
    logic [NLANE-1:0][NUM_W-1:0] num;
    logic [30:0]                 dp;
    logic [2:0]                  neg;
  } sq_pay_t;

  typedef struct packed {
    logic [63:0] sum;
    sq_pay_t     pay;
  } s5_t;

  // carried alongside the divider chain
  typedef struct packed {
    logic [30:0]      dp;
    logic [2:0]       neg;
    logic             zero;
    logic [NLANE-1:0] sat;
  } dv_pay_t;

endpackage

// File: hw/rtl/dtv_pipe_reg.sv
// ----------------------------------------------------------------------------
// dtv_pipe_reg
// one pipeline register with valid/ready, fills bubbles
// ----------------------------------------------------------------------------
module dtv_pipe_reg #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [PW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [PW-1:0] out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/dtv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// dtv_sqrt_cell
// one result bit of a pipelined integer square root
// ----------------------------------------------------------------------------
module dtv_sqrt_cell
  import dtv_pkg::*;
#(
  parameter int BIT = 0,
  parameter int PW  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_rem,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_rem,
  output logic [ROOT_W-1:0] out_root,
  output logic [PW-1:0]     out_pay
);

  logic [65:0] trial;
  logic        take;

  // trial = (2*root + 2^bit) * 2^bit, root holds only bits above this one
  always_comb begin
    trial = ({34'd0, in_root} << (BIT + 1)) + (66'd1 << (2 * BIT));
    take  = {2'b00, in_rem} >= trial;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_pay <= in_pay;
      if (take) begin
        out_rem  <= in_rem - trial[63:0];
        out_root <= in_root | (ROOT_W'(1) << BIT);
      end else begin
        out_rem  <= in_rem;
        out_root <= in_root;
      end
    end
  end

endmodule

// File: hw/rtl/dtv_div_cell.sv
// ----------------------------------------------------------------------------
// dtv_div_cell
// one quotient bit of six restoring divisions by a shared divisor
// ----------------------------------------------------------------------------
module dtv_div_cell
  import dtv_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEN_W-1:0] in_den,
  input  rem_arr_t         in_rem,
  input  quo_arr_t         in_lo,
  input  quo_arr_t         in_quo,
  input  logic [PW-1:0]    in_pay,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DEN_W-1:0] out_den,
  output rem_arr_t         out_rem,
  output quo_arr_t         out_lo,
  output quo_arr_t         out_quo,
  output logic [PW-1:0]    out_pay
);

  rem_arr_t rem_next;
  quo_arr_t quo_next;
  quo_arr_t lo_next;

  always_comb begin
    logic [DEN_W:0] t;
    for (int k = 0; k < NLANE; k++) begin
      t = {in_rem[k], in_lo[k][QUO_W-1]};
      lo_next[k] = {in_lo[k][QUO_W-2:0], 1'b0};
      if (t >= {1'b0, in_den}) begin
        rem_next[k] = DEN_W'(t - {1'b0, in_den});
        quo_next[k] = {in_quo[k][QUO_W-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DEN_W-1:0];
        quo_next[k] = {in_quo[k][QUO_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_den <= in_den;
      out_rem <= rem_next;
      out_lo  <= lo_next;
      out_quo <= quo_next;
      out_pay <= in_pay;
    end
  end

endmodule

// File: hw/rtl/dispersion_tensor_from_velocity.sv
// ----------------------------------------------------------------------------
// dispersion_tensor_from_velocity
// scheidegger dispersion tensor from a pore velocity vector, Q16.16
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output accepts; every stage is a
//   register with its own valid bit, so bubbles collapse and input keeps
//   flowing while output waits until all 72 stages hold a word
// most latency is in the 32-cell square root row and the 32-cell divider row
// reset: rst clears all valid bits and the configuration registers
// ----------------------------------------------------------------------------
module dispersion_tensor_from_velocity
  import dtv_pkg::*;
#(
  parameter int DIM = DTV_DIM
) (
  input  logic         clk,
  input  logic         rst,
  // apb configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vel_x, vel_y, vel_z, item_diffusivity, item_alpha_long, item_alpha_trans
  input  logic [191:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // d_xx, d_yy, d_zz, d_xy, d_xz, d_yz
  output logic [191:0] m_axis_tdata
);

  localparam int NSTEP = 32;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic        reg_source;
  logic [30:0] reg_dp;
  logic [30:0] reg_al;
  logic [30:0] reg_at;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_source <= 1'b0;
      reg_dp     <= '0;
      reg_al     <= '0;
      reg_at     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SOURCE: reg_source <= pwdata[0];
        REG_DIFF:   reg_dp     <= pwdata[30:0];
        REG_ALONG:  reg_al     <= pwdata[30:0];
        REG_ATRANS: reg_at     <= pwdata[30:0];
        default:    reg_source <= reg_source;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SOURCE: prdata = {31'd0, reg_source};
      REG_DIFF:   prdata = {1'b0, reg_dp};
      REG_ALONG:  prdata = {1'b0, reg_al};
      REG_ATRANS: prdata = {1'b0, reg_at};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage 0: unpack, mask components beyond DIM, magnitudes, coefficients
  // --------------------------------------------------------------------------
  s0_t  s0_in;
  s0_t  s0;
  logic v0;
  logic r0;

  always_comb begin
    logic [31:0] v;
    for (int i = 0; i < 3; i++) begin
      v = (i < DIM) ? s_axis_tdata[32*i +: 32] : 32'd0;
      s0_in.sgn[i] = v[31];
      s0_in.mag[i] = v[31] ? (~v + 32'd1) : v;
    end
    if (reg_source) begin
      s0_in.dp = s_axis_tdata[126:96];
      s0_in.al = s_axis_tdata[157:127];
      s0_in.at = s_axis_tdata[188:158];
    end else begin
      s0_in.dp = reg_dp;
      s0_in.al = reg_al;
      s0_in.at = reg_at;
    end
  end

  dtv_pipe_reg #(.PW($bits(s0_t))) u_r0 (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s0_in),
    .out_valid(v0), .out_ready(r0), .out_data(s0)
  );

  // --------------------------------------------------------------------------
  // stage 1: squares and cross products of magnitudes, off-diagonal sign
  // --------------------------------------------------------------------------
  s1_t  s1_in;
  s1_t  s1;
  logic v1;
  logic r1;

  always_comb begin
    int pa;
    int pb;
    for (int i = 0; i < 3; i++) begin
      s1_in.sq[i] = {32'd0, s0.mag[i]} * {32'd0, s0.mag[i]};
    end
    for (int k = 0; k < 3; k++) begin
      // pairs xy, xz, yz
      pa = (k == 2) ? 1 : 0;
      pb = (k == 0) ? 1 : 2;
      s1_in.pr[k]  = {32'd0, s0.mag[pa]} * {32'd0, s0.mag[pb]};
      s1_in.neg[k] = (s0.at > s0.al) ^ (s0.sgn[pa] ^ s0.sgn[pb]);
    end
    s1_in.dp   = s0.dp;
    s1_in.al   = s0.al;
    s1_in.at   = s0.at;
    s1_in.dmag = (s0.at > s0.al) ? (s0.at - s0.al) : (s0.al - s0.at);
  end

  dtv_pipe_reg #(.PW($bits(s1_t))) u_r1 (
    .clk(clk), .rst(rst),
    .in_valid(v0), .in_ready(r0), .in_data(s1_in),
    .out_valid(v1), .out_ready(r1), .out_data(s1)
  );

  // --------------------------------------------------------------------------
  // stage 2: sum of squares and the sum of the other two per axis
  // --------------------------------------------------------------------------
  s2_t  s2_in;
  s2_t  s2;
  logic v2;
  logic r2;

  always_comb begin
    s2_in.sum     = s1.sq[0] + s1.sq[1] + s1.sq[2];
    s2_in.rest[0] = s1.sq[1] + s1.sq[2];
    s2_in.rest[1] = s1.sq[0] + s1.sq[2];
    s2_in.rest[2] = s1.sq[0] + s1.sq[1];
    s2_in.sq      = s1.sq;
    s2_in.pr      = s1.pr;
    s2_in.dp      = s1.dp;
    s2_in.al      = s1.al;
    s2_in.at      = s1.at;
    s2_in.dmag    = s1.dmag;
    s2_in.neg     = s1.neg;
  end

  dtv_pipe_reg #(.PW($bits(s2_t))) u_r2 (
    .clk(clk), .rst(rst),
    .in_valid(v1), .in_ready(r1), .in_data(s2_in),
    .out_valid(v2), .out_ready(r2), .out_data(s2)
  );

  // --------------------------------------------------------------------------
  // stage 3: 31x32 partial products of the numerators
  // --------------------------------------------------------------------------
  s3_t  s3_in;
  s3_t  s3;
  logic v3;
  logic r3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_in.pal_lo[i]  = {32'd0, s2.al} * {31'd0, s2.sq[i][31:0]};
      s3_in.pal_hi[i]  = {32'd0, s2.al} * {31'd0, s2.sq[i][63:32]};
      s3_in.pat_lo[i]  = {32'd0, s2.at} * {31'd0, s2.rest[i][31:0]};
      s3_in.pat_hi[i]  = {32'd0, s2.at} * {31'd0, s2.rest[i][63:32]};
      s3_in.poff_lo[i] = {32'd0, s2.dmag} * {31'd0, s2.pr[i][31:0]};
      s3_in.poff_hi[i] = {32'd0, s2.dmag} * {31'd0, s2.pr[i][63:32]};
    end
    s3_in.sum = s2.sum;
    s3_in.dp  = s2.dp;
    s3_in.neg = s2.neg;
  end

  dtv_pipe_reg #(.PW($bits(s3_t))) u_r3 (
    .clk(clk), .rst(rst),
    .in_valid(v2), .in_ready(r2), .in_data(s3_in),
    .out_valid(v3), .out_ready(r3), .out_data(s3)
  );

  // --------------------------------------------------------------------------
  // stage 4: join partial products
  // --------------------------------------------------------------------------
  s4_t  s4_in;
  s4_t  s4;
  logic v4;
  logic r4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_in.na[i]   = {33'd0, s3.pal_lo[i]} + {1'b0, s3.pal_hi[i], 32'd0};
      s4_in.nb[i]   = {33'd0, s3.pat_lo[i]} + {1'b0, s3.pat_hi[i], 32'd0};
      s4_in.noff[i] = {33'd0, s3.poff_lo[i]} + {1'b0, s3.poff_hi[i], 32'd0};
    end
    s4_in.sum = s3.sum;
    s4_in.dp  = s3.dp;
    s4_in.neg = s3.neg;
  end

  dtv_pipe_reg #(.PW($bits(s4_t))) u_r4 (
    .clk(clk), .rst(rst),
    .in_valid(v3), .in_ready(r3), .in_data(s4_in),
    .out_valid(v4), .out_ready(r4), .out_data(s4)
  );

  // --------------------------------------------------------------------------
  // stage 5: diagonal numerators, lanes 0..2 diagonal, 3..5 off-diagonal
  // --------------------------------------------------------------------------
  s5_t  s5_in;
  s5_t  s5;
  logic v5;
  logic r5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_in.pay.num[i]     = s4.na[i] + s4.nb[i];
      s5_in.pay.num[i + 3] = s4.noff[i];
    end
    s5_in.sum     = s4.sum;
    s5_in.pay.dp  = s4.dp;
    s5_in.pay.neg = s4.neg;
  end

  dtv_pipe_reg #(.PW($bits(s5_t))) u_r5 (
    .clk(clk), .rst(rst),
    .in_valid(v4), .in_ready(r4), .in_data(s5_in),
    .out_valid(v5), .out_ready(r5), .out_data(s5)
  );

  // --------------------------------------------------------------------------
  // square root row: one root bit per cell, msb first
  // --------------------------------------------------------------------------
  logic [NSTEP:0]             sq_v;
  logic [NSTEP:0]             sq_r;
  logic [NSTEP:0][63:0]       sq_rem;
  logic [NSTEP:0][ROOT_W-1:0] sq_root;
  sq_pay_t [NSTEP:0]          sq_pay;

  assign sq_v[0]    = v5;
  assign r5         = sq_r[0];
  assign sq_rem[0]  = s5.sum;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = s5.pay;

  for (genvar g = 0; g < NSTEP; g++) begin : g_sqrt
    dtv_sqrt_cell #(.BIT(ROOT_W - 1 - g), .PW($bits(sq_pay_t))) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(sq_v[g]), .in_ready(sq_r[g]),
      .in_rem(sq_rem[g]), .in_root(sq_root[g]), .in_pay(sq_pay[g]),
      .out_valid(sq_v[g+1]), .out_ready(sq_r[g+1]),
      .out_rem(sq_rem[g+1]), .out_root(sq_root[g+1]), .out_pay(sq_pay[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // stage 6: divisor |v| << 16, overflow check, first partial remainders
  // --------------------------------------------------------------------------
  localparam int S6_W = DEN_W + $bits(rem_arr_t) + 2 * $bits(quo_arr_t) + $bits(dv_pay_t);

  logic [DEN_W-1:0] d6_den_in;
  rem_arr_t         d6_rem_in;
  quo_arr_t         d6_lo_in;
  dv_pay_t          d6_pay_in;
  logic [DEN_W-1:0] d6_den;
  rem_arr_t         d6_rem;
  quo_arr_t         d6_lo;
  dv_pay_t          d6_pay;
  logic [QUO_W*NLANE-1:0] d6_unused;

  always_comb begin
    sq_pay_t p;
    p = sq_pay[NSTEP];
    d6_den_in = {sq_root[NSTEP], 16'd0};
    for (int k = 0; k < NLANE; k++) begin
      // quotient of 2^32 or more only ever saturates
      d6_pay_in.sat[k] = p.num[k][NUM_W-1:32] >= {16'd0, d6_den_in};
      d6_rem_in[k]     = p.num[k][79:32];
      d6_lo_in[k]      = p.num[k][31:0];
    end
    d6_pay_in.dp   = p.dp;
    d6_pay_in.neg  = p.neg;
    d6_pay_in.zero = (sq_root[NSTEP] == '0);
  end

  logic dv_v0;
  logic dv_r0;

  dtv_pipe_reg #(.PW(S6_W)) u_r6 (
    .clk(clk), .rst(rst),
    .in_valid(sq_v[NSTEP]), .in_ready(sq_r[NSTEP]),
    .in_data({d6_den_in, d6_rem_in, d6_lo_in, {(QUO_W*NLANE){1'b0}}, d6_pay_in}),
    .out_valid(dv_v0), .out_ready(dv_r0),
    .out_data({d6_den, d6_rem, d6_lo, d6_unused, d6_pay})
  );

  // --------------------------------------------------------------------------
  // divider row: one quotient bit per cell for all six lanes
  // --------------------------------------------------------------------------
  logic [NSTEP:0]            dv_v;
  logic [NSTEP:0]            dv_r;
  logic [NSTEP:0][DEN_W-1:0] dv_den;
  rem_arr_t [NSTEP:0]        dv_rem;
  quo_arr_t [NSTEP:0]        dv_lo;
  quo_arr_t [NSTEP:0]        dv_quo;
  dv_pay_t [NSTEP:0]         dv_pay;

  assign dv_v[0]   = dv_v0;
  assign dv_r0     = dv_r[0];
  assign dv_den[0] = d6_den;
  assign dv_rem[0] = d6_rem;
  assign dv_lo[0]  = d6_lo;
  assign dv_quo[0] = d6_unused;
  assign dv_pay[0] = d6_pay;

  for (genvar g = 0; g < NSTEP; g++) begin : g_div
    dtv_div_cell #(.PW($bits(dv_pay_t))) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(dv_v[g]), .in_ready(dv_r[g]),
      .in_den(dv_den[g]), .in_rem(dv_rem[g]), .in_lo(dv_lo[g]),
      .in_quo(dv_quo[g]), .in_pay(dv_pay[g]),
      .out_valid(dv_v[g+1]), .out_ready(dv_r[g+1]),
      .out_den(dv_den[g+1]), .out_rem(dv_rem[g+1]), .out_lo(dv_lo[g+1]),
      .out_quo(dv_quo[g+1]), .out_pay(dv_pay[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // output stage: add diffusivity, saturate, apply signs, mask beyond DIM
  // --------------------------------------------------------------------------
  logic [191:0] out_word;

  always_comb begin
    dv_pay_t     p;
    logic [31:0] q;
    logic        big;
    logic [31:0] lim;
    p = dv_pay[NSTEP];
    for (int i = 0; i < 3; i++) begin
      q   = p.zero ? 32'd0 : dv_quo[NSTEP][i];
      big = !p.zero && p.sat[i];
      lim = 32'h7FFF_FFFF - {1'b0, p.dp};
      if (i >= DIM) begin
        out_word[32*i +: 32] = 32'd0;
      end else if (big || q > lim) begin
        out_word[32*i +: 32] = 32'h7FFF_FFFF;
      end else begin
        out_word[32*i +: 32] = {1'b0, p.dp} + q;
      end
    end
    for (int k = 0; k < 3; k++) begin
      q   = dv_quo[NSTEP][k + 3];
      big = p.sat[k + 3];
      if (p.zero || (q == 32'd0 && !big)) begin
        out_word[32*(k+3) +: 32] = 32'd0;
      end else if (p.neg[k]) begin
        // most negative value when the magnitude reaches 2^31
        out_word[32*(k+3) +: 32] = (big || q[31]) ? 32'h8000_0000 : (~q + 32'd1);
      end else begin
        out_word[32*(k+3) +: 32] = (big || q >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
      end
    end
  end

  dtv_pipe_reg #(.PW(192)) u_rout (
    .clk(clk), .rst(rst),
    .in_valid(dv_v[NSTEP]), .in_ready(dv_r[NSTEP]), .in_data(out_word),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule
